// ----- hdl/tvg3_pkg.sv -----
// Package for the TV gradient stencil: constants and state enum.
package tvg3_pkg;

	localparam int MAX_SIZE_X_DEF = 64;
	localparam int MAX_SIZE_Y_DEF = 64;
	localparam int VOXEL_BITS_DEF = 16;
	localparam int VOXEL_FRAC_BITS_DEF = 8;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 32;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_EPS = 2'd3;

	localparam int GRAD_BITS = 16;
	localparam int Z_BITS = 16;
	// Stencil weight of the center voxel in the first term.
	localparam int CENTER_WEIGHT = 3;
	// Number of stored planes.
	localparam int PLANES = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_SQRT,
		ST_DIV,
		ST_TERM,
		ST_OUT1,
		ST_OUT2
	} state_t;

endpackage

// ----- hdl/tv_gradient_3d_stencil_unit.sv -----
// Top level of the streaming 3D total-variation gradient stencil.
//
// Voxels come in on the input channel (valid/stall) in x-fastest order, one
// transfer per voxel. Each accepted voxel yields zero, one or two result
// transfers on the output channel: the gradient of the voxel one plane
// back, and, for voxels of the last plane, a zero result of their own.
// run_last marks the last result of each input voxel.
// The block holds one voxel at a time. A voxel with no interior gradient
// goes from idle through a position check to its result, and then to its
// own zero if it has one. An interior voxel reads twelve neighbors on one
// store read port, lands the last read, then runs four square roots and
// four divides on one shared shift/subtract unit, folding each term into
// the sum. Results are held stable while the receiver stalls, and no new
// voxel is taken meanwhile.
// Reset clears counters, the write pointer and the registers to their
// defaults (64 x 64 x 64, eps 1). The plane store is not cleared; it is
// read only where it has been written. Configuration writes are taken in
// any cycle but are meant for idle periods only.
module tv_gradient_3d_stencil_unit #(
	parameter int MAX_SIZE_X = tvg3_pkg::MAX_SIZE_X_DEF,
	parameter int MAX_SIZE_Y = tvg3_pkg::MAX_SIZE_Y_DEF,
	parameter int VOXEL_BITS = tvg3_pkg::VOXEL_BITS_DEF,
	parameter int VOXEL_FRAC_BITS = tvg3_pkg::VOXEL_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [tvg3_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [tvg3_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [VOXEL_BITS-1:0] voxel_value,
	input  logic volume_start,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [tvg3_pkg::GRAD_BITS-1:0] gradient_value,
	output logic [$clog2(MAX_SIZE_X)-1:0] out_x,
	output logic [$clog2(MAX_SIZE_Y)-1:0] out_y,
	output logic [tvg3_pkg::Z_BITS-1:0] out_z,
	output logic zero_denominator,
	output logic run_last
);
	localparam int XB = $clog2(MAX_SIZE_X);
	localparam int YB = $clog2(MAX_SIZE_Y);
	localparam int DEPTH = tvg3_pkg::PLANES * MAX_SIZE_X * MAX_SIZE_Y;
	localparam int AB = $clog2(DEPTH);
	localparam int LB = AB + 1;
	localparam int DB = VOXEL_BITS + 3;        // stencil difference width
	localparam int SB = 2 * DB + 2;            // sum of squares
	localparam int EB = (2 * VOXEL_FRAC_BITS >= 16) ? 32 + 2 * VOXEL_FRAC_BITS - 16 : 32;
	localparam int XSB = ((SB > EB) ? SB : EB) + 1;
	localparam int RB = (XSB + 17) / 2;        // root width
	localparam int RIN = 2 * RB;               // radicand width, whole bit pairs
	localparam int NB = DB + 20;               // scaled numerator
	localparam int QB = 41;
	localparam int TB = QB + 3;                // sum of four terms
	localparam int RSB = RIN + 2;
	localparam int CX = 7;                     // config extent width

	// ------------------------------------------------------------------
	// Configuration registers.
	logic [CX-1:0] size_x_q, size_y_q;
	logic [tvg3_pkg::Z_BITS-1:0] size_z_q;
	logic [31:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= CX'(64);
			size_y_q <= CX'(64);
			size_z_q <= 16'd64;
			eps_q <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				tvg3_pkg::REG_SIZE_X: size_x_q <= cfg_data[CX-1:0];
				tvg3_pkg::REG_SIZE_Y: size_y_q <= cfg_data[CX-1:0];
				tvg3_pkg::REG_SIZE_Z: size_z_q <= cfg_data[15:0];
				tvg3_pkg::REG_EPS: eps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective extents, clamped to 1..max.
	logic [XB:0] nx;
	logic [YB:0] ny;
	logic [tvg3_pkg::Z_BITS-1:0] nz;
	logic [LB-1:0] plen, len;
	always_comb begin
		if (size_x_q == '0) nx = (XB+1)'(1);
		else if (32'(size_x_q) > MAX_SIZE_X) nx = (XB+1)'(MAX_SIZE_X);
		else nx = (XB+1)'(size_x_q);
		if (size_y_q == '0) ny = (YB+1)'(1);
		else if (32'(size_y_q) > MAX_SIZE_Y) ny = (YB+1)'(MAX_SIZE_Y);
		else ny = (YB+1)'(size_y_q);
		nz = (size_z_q == '0) ? 16'd1 : size_z_q;
		plen = LB'(nx) * LB'(ny);
		len = LB'(plen << 1);
	end

	logic [EB-1:0] eps_s;
	always_comb begin
		if (2 * VOXEL_FRAC_BITS >= 16)
			eps_s = EB'(64'(eps_q)
				<< ((2 * VOXEL_FRAC_BITS >= 16) ? 2 * VOXEL_FRAC_BITS - 16 : 0));
		else eps_s = EB'(eps_q >> (16 - 2 * VOXEL_FRAC_BITS));
	end

	// ------------------------------------------------------------------
	// Plane store, one write and one registered read port.
	logic signed [VOXEL_BITS-1:0] store_mem [DEPTH];
	logic signed [VOXEL_BITS-1:0] rd_data_q;
	logic [AB-1:0] rd_addr;
	logic st_we;
	logic [LB-1:0] wp_q;
	logic signed [VOXEL_BITS-1:0] voxel_q;

	always_ff @(posedge clk) begin
		if (st_we) store_mem[wp_q[AB-1:0]] <= voxel_q;
		rd_data_q <= store_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// Sequencer state.
	tvg3_pkg::state_t state_q, state_d;
	logic [XB:0] px_q;
	logic [YB:0] py_q;
	logic [tvg3_pkg::Z_BITS-1:0] pz_q;
	logic [3:0] rd_cnt_q;            // store read index, 0..11
	logic [1:0] term_q;              // which of the four terms
	logic [6:0] step_q;              // iteration counter of shared unit
	logic signed [VOXEL_BITS-1:0] nb_q [12];  // loaded neighbours
	logic [RSB-1:0] rem_q;
	logic [RIN-1:0] rad_q;
	logic [RB-1:0] root_q;
	logic [NB+QB-1:0] divw_q;        // numerator shift register / quotient
	logic [RB:0] drem_q;
	logic signed [TB-1:0] acc_q;
	logic zf_q, interior_q, g_en_q, own_en_q;
	logic signed [DB-1:0] num_q;

	// Neighbour offsets back from the write pointer, in read order:
	// f, ax, ay, az, b, by, bz, c, cx, czv, dx, dy.
	logic [LB-1:0] back_off;
	always_comb begin
		case (rd_cnt_q)
			4'd0: back_off = plen;
			4'd1: back_off = plen + LB'(1);
			4'd2: back_off = plen + LB'(nx);
			4'd3: back_off = LB'(plen << 1);
			4'd4: back_off = plen - LB'(1);
			4'd5: back_off = plen - LB'(1) + LB'(nx);
			4'd6: back_off = LB'(plen << 1) - LB'(1);
			4'd7: back_off = plen - LB'(nx);
			4'd8: back_off = plen - LB'(nx) + LB'(1);
			4'd9: back_off = LB'(plen << 1) - LB'(nx);
			4'd10: back_off = LB'(1);
			default: back_off = LB'(nx);
		endcase
	end
	logic [LB:0] raw_addr;
	always_comb begin
		raw_addr = {1'b0, wp_q} + {1'b0, len} - {1'b0, back_off};
		if (raw_addr >= {1'b0, len}) raw_addr = raw_addr - {1'b0, len};
		rd_addr = raw_addr[AB-1:0];
	end

	// Term operands chosen by term index.
	logic signed [DB-1:0] tn, t1, t2, t3;
	logic signed [DB-1:0] vf, vb, vc, vd;
	always_comb begin
		vf = DB'(nb_q[0]);
		vb = DB'(nb_q[4]);
		vc = DB'(nb_q[7]);
		vd = DB'(voxel_q);
		case (term_q)
			2'd0: begin
				tn = DB'(tvg3_pkg::CENTER_WEIGHT) * vf - DB'(nb_q[1]) - DB'(nb_q[2])
					- DB'(nb_q[3]);
				t1 = vf - DB'(nb_q[1]);
				t2 = vf - DB'(nb_q[2]);
				t3 = vf - DB'(nb_q[3]);
			end
			2'd1: begin
				tn = vb - vf;
				t1 = vb - vf;
				t2 = vb - DB'(nb_q[5]);
				t3 = vb - DB'(nb_q[6]);
			end
			2'd2: begin
				tn = vc - vf;
				t1 = vc - DB'(nb_q[8]);
				t2 = vc - vf;
				t3 = vc - DB'(nb_q[9]);
			end
			default: begin
				tn = vd - vf;
				t1 = vd - DB'(nb_q[10]);
				t2 = vd - DB'(nb_q[11]);
				t3 = vd - vf;
			end
		endcase
	end

	function automatic logic [DB-1:0] absd(input logic signed [DB-1:0] v);
		absd = v[DB-1] ? DB'(-v) : DB'(v);
	endfunction

	// Sum of squares, combinational; taken once per term at the first ST_SQRT step.
	logic [DB-1:0] m1, m2, m3;
	logic [RIN-1:0] radicand;
	always_comb begin
		m1 = absd(t1);
		m2 = absd(t2);
		m3 = absd(t3);
		radicand = RIN'({(XSB'(SB'(m1) * SB'(m1)) + XSB'(SB'(m2) * SB'(m2))
			+ XSB'(SB'(m3) * SB'(m3)) + XSB'(eps_s)), 16'd0});
	end

	// Shared shift/subtract step: digit-recurrence root or restoring divide.
	localparam int RSTEPS = RB;
	localparam int DSTEPS = NB;
	logic [RSB-1:0] sq_trial;
	logic [RB:0] dv_trial;
	always_comb begin
		sq_trial = {rem_q[RSB-3:0], rad_q[RIN-1 -: 2]} - RSB'({root_q, 2'b01});
		dv_trial = {drem_q[RB-1:0], divw_q[NB-1]} - {1'b0, root_q};
	end

	// Position tests.
	logic pz_ge1, interior, vol_end;
	always_comb begin
		pz_ge1 = pz_q != '0;
		interior = (px_q >= (XB+1)'(1)) && ((XB+2)'(px_q) + (XB+2)'(2) <= (XB+2)'(nx))
			&& (py_q >= (YB+1)'(1)) && ((YB+2)'(py_q) + (YB+2)'(2) <= (YB+2)'(ny))
			&& (pz_q >= 16'd2) && (17'(pz_q) + 17'd1 <= 17'(nz));
		vol_end = (px_q + (XB+1)'(1) >= nx) && (py_q + (YB+1)'(1) >= ny)
			&& (17'(pz_q) + 17'd1 >= 17'(nz));
	end

	logic signed [TB-1:0] sat_in;
	logic signed [tvg3_pkg::GRAD_BITS-1:0] sat_g;
	always_comb begin
		sat_in = acc_q;
		if (sat_in > TB'(32767)) sat_g = 16'sd32767;
		else if (sat_in < -TB'(32768)) sat_g = -16'sd32768;
		else sat_g = sat_in[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tvg3_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	logic in_fire, out_fire;
	assign in_fire = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		st_we = 1'b0;
		case (state_q)
			tvg3_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = tvg3_pkg::ST_READ;
			end
			tvg3_pkg::ST_READ: begin
				// The first read cycle decides on the live position test.
				if (rd_cnt_q == 4'd0) begin
					if (!interior) state_d = tvg3_pkg::ST_OUT1;
				end else if (rd_cnt_q == 4'd11) state_d = tvg3_pkg::ST_LOAD;
			end
			tvg3_pkg::ST_LOAD: state_d = tvg3_pkg::ST_SQRT;
			tvg3_pkg::ST_SQRT: if (step_q == 7'(RSTEPS - 1)) state_d = tvg3_pkg::ST_DIV;
			tvg3_pkg::ST_DIV: if (step_q == 7'(DSTEPS - 1)) state_d = tvg3_pkg::ST_TERM;
			tvg3_pkg::ST_TERM: begin
				if (term_q == 2'd3) state_d = tvg3_pkg::ST_OUT1;
				else state_d = tvg3_pkg::ST_SQRT;
			end
			tvg3_pkg::ST_OUT1: begin
				out_valid = g_en_q;
				if (!g_en_q || !out_stall) begin
					state_d = own_en_q ? tvg3_pkg::ST_OUT2 : tvg3_pkg::ST_IDLE;
					st_we = !own_en_q;
				end
			end
			tvg3_pkg::ST_OUT2: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = tvg3_pkg::ST_IDLE;
					st_we = 1'b1;
				end
			end
			default: state_d = tvg3_pkg::ST_IDLE;
		endcase
	end

	// Datapath and counters.
	logic [RB-1:0] q_root;
	always_comb q_root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			wp_q <= '0;
			rd_cnt_q <= '0;
			term_q <= '0;
			step_q <= '0;
			interior_q <= 1'b0;
			g_en_q <= 1'b0;
			own_en_q <= 1'b0;
			zf_q <= 1'b0;
		end else begin
			case (state_q)
				tvg3_pkg::ST_IDLE: begin
					if (in_fire) begin
						logic [LB-1:0] wpn;
						wpn = volume_start ? '0 : wp_q;
						if (wpn >= len) wpn = '0;
						wp_q <= wpn;
						if (volume_start) begin
							px_q <= '0;
							py_q <= '0;
							pz_q <= '0;
						end
						rd_cnt_q <= '0;
						term_q <= '0;
						zf_q <= 1'b0;
					end
				end
				tvg3_pkg::ST_READ: begin
					if (rd_cnt_q == 4'd0) begin
						interior_q <= interior;
						g_en_q <= pz_ge1;
						own_en_q <= 17'(pz_q) + 17'd1 == 17'(nz);
					end
					rd_cnt_q <= rd_cnt_q + 4'd1;
					step_q <= '0;
				end
				tvg3_pkg::ST_SQRT: step_q <= (step_q == 7'(RSTEPS - 1)) ? '0 : step_q + 7'd1;
				tvg3_pkg::ST_DIV: step_q <= (step_q == 7'(DSTEPS - 1)) ? '0 : step_q + 7'd1;
				tvg3_pkg::ST_TERM: begin
					if (root_q == '0) zf_q <= 1'b1;
					term_q <= term_q + 2'd1;
				end
				tvg3_pkg::ST_OUT1, tvg3_pkg::ST_OUT2: begin
					if (st_we) begin
						// The write pointer returns to zero at the end of a volume.
						if (vol_end) wp_q <= '0;
						else wp_q <= (wp_q + LB'(1) >= len) ? '0 : wp_q + LB'(1);
						if (px_q + (XB+1)'(1) >= nx) begin
							px_q <= '0;
							if (py_q + (YB+1)'(1) >= ny) begin
								py_q <= '0;
								if (17'(pz_q) + 17'd1 >= 17'(nz)) pz_q <= '0;
								else pz_q <= pz_q + 16'd1;
							end else py_q <= py_q + (YB+1)'(1);
						end else px_q <= px_q + (XB+1)'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload side of the sequencer, no reset.
	logic [NB-1:0] num_mag;
	always_comb num_mag = NB'({absd(tn), 20'd0});

	always_ff @(posedge clk) begin
		case (state_q)
			tvg3_pkg::ST_IDLE: begin
				voxel_q <= voxel_value;
				acc_q <= '0;
			end
			tvg3_pkg::ST_READ: begin
				// Read data arrives the cycle after its address.
				if (rd_cnt_q != 4'd0) nb_q[rd_cnt_q - 4'd1] <= rd_data_q;
			end
			tvg3_pkg::ST_LOAD: begin
				nb_q[11] <= rd_data_q;
				rem_q <= '0;
				root_q <= '0;
			end
			tvg3_pkg::ST_SQRT: begin
				if (step_q == '0) begin
					// First step takes the radicand fresh.
					logic [RSB-1:0] tr;
					tr = RSB'(radicand[RIN-1 -: 2]) - RSB'(1);
					rad_q <= radicand << 2;
					if (!tr[RSB-1]) begin
						rem_q <= tr;
						root_q <= RB'(1);
					end else begin
						rem_q <= RSB'(radicand[RIN-1 -: 2]);
						root_q <= '0;
					end
				end else begin
					rad_q <= rad_q << 2;
					if (!sq_trial[RSB-1]) begin
						rem_q <= sq_trial;
						root_q <= {root_q[RB-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[RSB-3:0], rad_q[RIN-1 -: 2]};
						root_q <= {root_q[RB-2:0], 1'b0};
					end
				end
				drem_q <= '0;
				divw_q <= {{QB{1'b0}}, num_mag};
				num_q <= tn;
			end
			tvg3_pkg::ST_DIV: begin
				if (!dv_trial[RB]) begin
					drem_q <= dv_trial;
					divw_q <= {divw_q[NB+QB-2:0], 1'b1};
				end else begin
					drem_q <= {drem_q[RB-1:0], divw_q[NB-1]};
					divw_q <= {divw_q[NB+QB-2:0], 1'b0};
				end
			end
			tvg3_pkg::ST_TERM: begin
				logic [NB+QB-1:0] qv;
				logic signed [TB-1:0] tv;
				// After all dividend bits are shifted through, the quotient
				// fills the low bits of the shift register.
				qv = (NB+QB)'(divw_q[NB-1:0]);
				if (q_root == '0) tv = '0;
				else if (qv > (NB+QB)'(1) << 40) tv = TB'(1) <<< 40;
				else tv = TB'(qv);
				if (num_q[DB-1]) tv = -tv;
				if (term_q == 2'd0) acc_q <= acc_q + tv;
				else acc_q <= acc_q - tv;
			end
			default: ;
		endcase
	end

	// Output register view.
	always_comb begin
		if (state_q == tvg3_pkg::ST_OUT2) begin
			gradient_value = '0;
			out_z = pz_q;
			zero_denominator = 1'b0;
			run_last = 1'b1;
		end else begin
			gradient_value = interior_q ? sat_g : '0;
			out_z = pz_q - 16'd1;
			zero_denominator = interior_q && zf_q;
			run_last = !own_en_q;
		end
		out_x = px_q[XB-1:0];
		out_y = py_q[YB-1:0];
	end

	// ------------------------------------------------------------------
	// Assertions.
	a_no_in_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tvg3_pkg::ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_out_only_out_states: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == tvg3_pkg::ST_OUT1 || state_q == tvg3_pkg::ST_OUT2))
		else $error("output valid outside output states");
	a_in_then_read: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == tvg3_pkg::ST_READ)
		else $error("accepted voxel not processed");
	a_own_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && state_q == tvg3_pkg::ST_OUT2) |-> run_last)
		else $error("own zero must be last");
endmodule
